@@ rtl/isrt_pkg.sv @@
// Shared types and constants for the insertion sort engine.
package isrt_pkg;

    localparam int DEPTH = 64;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic ins;      // insert the accepted item's value
        logic shift;    // result taken: shift store down one place
        logic finish;   // final result of the set taken
    } t_cmd;

    typedef struct packed {
        logic last_entry;   // store holds exactly one entry
    } t_status;

endpackage

@@ rtl/isrt_datapath.sv @@
// Sorted store as a row of compare-and-shift cells, with entry count and drop flag.
module isrt_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isrt_pkg::t_cmd                i_cmd,
    input  logic signed [isrt_pkg::VAL_W-1:0] i_value,
    output isrt_pkg::t_status             o_status,
    output logic signed [isrt_pkg::VAL_W-1:0] o_sorted_value,
    output logic                          o_end_of_set,
    output logic                          o_overflowed
);
    import isrt_pkg::*;

    logic signed [VAL_W-1:0] r_store [DEPTH];
    logic signed [VAL_W-1:0] n_store [DEPTH];
    logic [DEPTH-1:0]        w_gt;
    logic [CNT_W-1:0]        r_count;
    logic                    r_ovf;
    logic                    w_full;

    assign w_full = (r_count == CNT_W'(DEPTH));

    // Each cell compares against the new value; entries above it move up one place.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_gt[i] = (CNT_W'(i) < r_count) && (r_store[i] > i_value);
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (w_gt[i] || (CNT_W'(i) == r_count)) begin
                if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                    n_store[i] = r_store[(i > 0) ? i - 1 : 0];
                end else begin
                    n_store[i] = i_value;
                end
            end else begin
                n_store[i] = r_store[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !w_full) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_store[i] <= n_store[i];
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_store[i] <= r_store[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end else if (i_cmd.shift) begin
                r_count <= r_count - CNT_W'(1);
                if (i_cmd.finish) begin
                    r_ovf <= 1'b0;
                end
            end
        end
    end

    assign o_status.last_entry = (r_count == CNT_W'(1));
    assign o_sorted_value      = r_store[0];
    assign o_end_of_set        = (r_count == CNT_W'(1));
    assign o_overflowed        = r_ovf;

endmodule

@@ rtl/isrt_ctrl.sv @@
// Load/drain controller for the insertion sort engine.
module isrt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  isrt_pkg::t_status  i_status,
    output isrt_pkg::t_cmd     o_cmd
);
    import isrt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.ins  = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                o_out_valid  = 1'b1;
                o_cmd.shift  = i_out_ready;
                o_cmd.finish = i_out_ready && i_status.last_entry;
                if (i_out_ready && i_status.last_entry) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

@@ rtl/insertion_sort_engine_core.sv @@
// Insertion sort engine: one value inserted per cycle while loading, set drained in ascending order.
// An item is inserted in the cycle it is accepted; one input item per cycle while loading.
// After the item marked last, the set drains one result per cycle,
// paced by the output ready; no input item is taken while draining.
// Each insert is a parallel compare-and-shift across all DEPTH cells.
// Reset (i_rst_n low, synchronous) empties the store and clears the drop flag.
module insertion_sort_engine_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [isrt_pkg::VAL_W-1:0] i_value,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [isrt_pkg::VAL_W-1:0] o_sorted_value,
    output logic                              o_end_of_set,
    output logic                              o_overflowed
);
    import isrt_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    isrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    isrt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_value        (i_value),
        .o_status       (w_status),
        .o_sorted_value (o_sorted_value),
        .o_end_of_set   (o_end_of_set),
        .o_overflowed   (o_overflowed)
    );

endmodule

@@ verif/isrt_sort_checker.sv @@
// Sort checker: predicts each drained set from accepted items and compares the results.
`timescale 1ns / 100ps

module isrt_sort_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic signed [isrt_pkg::VAL_W-1:0] i_value,
    input  logic                              i_last,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic signed [isrt_pkg::VAL_W-1:0] i_sorted_value,
    input  logic                              i_end_of_set,
    input  logic                              i_overflowed,
    output int                                o_fail_cnt,
    output int                                o_pending
);
    import isrt_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    eos;
        logic                    ovf;
    } t_sorted_result;

    logic signed [VAL_W-1:0] sort_store [DEPTH];
    int                      entry_cnt;
    logic                    drop_flag;
    t_sorted_result          drain_q [$];

    // Equal values keep arrival order: only strictly greater entries move up.
    function automatic void insert_sorted(input logic signed [VAL_W-1:0] v);
        int pos;
        if (entry_cnt >= DEPTH) begin
            drop_flag = 1'b1;
            return;
        end
        pos = entry_cnt;
        while (pos > 0 && sort_store[pos-1] > v) begin
            sort_store[pos] = sort_store[pos-1];
            pos--;
        end
        sort_store[pos] = v;
        entry_cnt++;
    endfunction

    function automatic void emit_set();
        t_sorted_result r;
        for (int k = 0; k < entry_cnt; k++) begin
            r.value = sort_store[k];
            r.eos   = (k == entry_cnt - 1);
            r.ovf   = drop_flag;
            drain_q.push_back(r);
        end
        entry_cnt = 0;
        drop_flag = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_sorted_result exp_r;
        if (!i_rst_n) begin
            entry_cnt = 0;
            drop_flag = 1'b0;
            drain_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (drain_q.size() == 0) begin
                    $display("%0t: unexpected result value=%0d eos=%0b ovf=%0b", $time,
                             i_sorted_value, i_end_of_set, i_overflowed);
                    o_fail_cnt++;
                end else begin
                    exp_r = drain_q.pop_front();
                    if (i_sorted_value !== exp_r.value) begin
                        $display("%0t: sorted_value expected %0d actual %0d", $time,
                                 exp_r.value, i_sorted_value);
                        o_fail_cnt++;
                    end
                    if (i_end_of_set !== exp_r.eos) begin
                        $display("%0t: end_of_set expected %0b actual %0b", $time,
                                 exp_r.eos, i_end_of_set);
                        o_fail_cnt++;
                    end
                    if (i_overflowed !== exp_r.ovf) begin
                        $display("%0t: overflowed expected %0b actual %0b", $time,
                                 exp_r.ovf, i_overflowed);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                insert_sorted(i_value);
                if (i_last)
                    emit_set();
            end
        end
        o_pending = drain_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: clock, reset, item traffic with random gaps, and the final verdict.
`timescale 1ns / 100ps

module tb_top;
    import isrt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int ITEM_TARGET  = 210;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic signed [VAL_W-1:0] i_value;
    logic                    i_last;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic signed [VAL_W-1:0] o_sorted_value;
    logic                    o_end_of_set;
    logic                    o_overflowed;

    int fail_cnt;
    int pending_cnt;
    int cycle_cnt = 0;
    int items_sent = 0;
    bit send_burst = 1'b0;
    bit take_burst = 1'b0;

    insertion_sort_engine_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_end_of_set   (o_end_of_set),
        .o_overflowed   (o_overflowed)
    );

    isrt_sort_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_value        (i_value),
        .i_last         (i_last),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_sorted_value (o_sorted_value),
        .i_end_of_set   (o_end_of_set),
        .i_overflowed   (o_overflowed),
        .o_fail_cnt     (fail_cnt),
        .o_pending      (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("insertion_sort_engine_core test failed");
            $finish;
        end
    end

    // Valid stays high across back-to-back items; it only drops for a gap.
    task automatic send_item(input logic signed [VAL_W-1:0] v, input logic l);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= l;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Mix of full range, a narrow band for duplicates, and the extremes.
    function automatic logic signed [VAL_W-1:0] rand_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 16) - 8;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_set(input int n);
        for (int k = 0; k < n; k++)
            send_item(rand_value(), k == n - 1);
    endtask

    initial begin
        int stall;
        i_out_ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                take_burst = ~take_burst;
            stall = take_burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        int set_idx;
        int set_size;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_value    <= '0;
        i_last     <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-entry set
        send_item(5, 1'b1);
        // extremes and repeats in one set
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(7, 1'b1);
        // all equal
        send_item(3, 1'b0);
        send_item(3, 1'b0);
        send_item(3, 1'b1);
        // descending then ascending arrival
        send_item(10, 1'b0);
        send_item(9, 1'b0);
        send_item(8, 1'b0);
        send_item(7, 1'b1);
        send_item(-4, 1'b0);
        send_item(-3, 1'b0);
        send_item(-2, 1'b1);

        // exactly full store once, and one overrun that also drops the last item
        set_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            send_burst = ($urandom_range(0, 3) == 0);
            if (set_idx == 2)
                set_size = DEPTH;
            else if (set_idx == 6)
                set_size = DEPTH + 3;
            else
                set_size = $urandom_range(1, 12);
            send_set(set_size);
            set_idx++;
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        wait (pending_cnt == 0);
        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("insertion_sort_engine_core test passed");
        else
            $display("insertion_sort_engine_core test failed");
        $finish;
    end

endmodule
